[src/eds_pkg.sv]
`timescale 1ns / 1ps

package eds_pkg;

   // field widths
   localparam int TIME_W = 32;
   localparam int TYPE_W = 3;
   localparam int TOKEN_W = 3;
   localparam int MASK_W = 8;

   // request kinds
   typedef enum logic [TYPE_W-1:0] {
      REQ_RESYNC   = 3'd0,
      REQ_SCHEDULE = 3'd1,
      REQ_ADVANCE  = 3'd2,
      REQ_CHECK    = 3'd3,
      REQ_REBASE   = 3'd4
   } req_kind_type;

   // shared adder operation
   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   // compare flags from the shared adder, valid for subtraction
   typedef struct packed {
      logic lt;
      logic eq;
   } alu_flags_type;

   // write enables into the token store
   typedef struct packed {
      logic sync_we;
      logic dl_we;
   } store_wr_type;

endpackage

[src/eds_alu.sv]
`timescale 1ns / 1ps

module eds_alu (
   input  eds_pkg::alu_op_type           op,
   input  logic [eds_pkg::TIME_W-1:0]    a,
   input  logic [eds_pkg::TIME_W-1:0]    b,
   output logic [eds_pkg::TIME_W-1:0]    res,
   output eds_pkg::alu_flags_type        flags
);

   logic                      sub;
   logic [eds_pkg::TIME_W:0]  a_ext;
   logic [eds_pkg::TIME_W:0]  b_ext;
   logic [eds_pkg::TIME_W:0]  sum;

   // one 33-bit adder: wrap result in the low bits, signed borrow on top
   assign sub   = (op == eds_pkg::ALU_SUB);
   assign a_ext = {a[eds_pkg::TIME_W-1], a};
   assign b_ext = sub ? ~{b[eds_pkg::TIME_W-1], b} : {b[eds_pkg::TIME_W-1], b};
   assign sum   = a_ext + b_ext + {{eds_pkg::TIME_W{1'b0}}, sub};

   assign res      = sum[eds_pkg::TIME_W-1:0];
   assign flags.lt = sum[eds_pkg::TIME_W];
   assign flags.eq = (sum[eds_pkg::TIME_W-1:0] == '0);

endmodule

[src/eds_token_store.sv]
`timescale 1ns / 1ps

module eds_token_store #(
   parameter int NUM_TOKENS = 5,
   parameter int IDX_W = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [IDX_W-1:0]              addr,
   input  eds_pkg::store_wr_type         wr,
   input  logic [eds_pkg::TIME_W-1:0]    wr_data,
   output logic [eds_pkg::TIME_W-1:0]    sync_rd,
   output logic [eds_pkg::TIME_W-1:0]    dl_rd
);

   logic [eds_pkg::TIME_W-1:0] sync_ff [NUM_TOKENS];
   logic [eds_pkg::TIME_W-1:0] dl_ff [NUM_TOKENS];

   // per-token last sync time and deadline, one shared address
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TOKENS; i++) begin
            sync_ff[i] <= '0;
            dl_ff[i]   <= '0;
         end
      end else begin
         if (wr.sync_we) begin
            sync_ff[addr] <= wr_data;
         end
         if (wr.dl_we) begin
            dl_ff[addr] <= wr_data;
         end
      end
   end

   assign sync_rd = sync_ff[addr];
   assign dl_rd   = dl_ff[addr];

endmodule

[src/event_deadline_scheduler_top.sv]
`timescale 1ns / 1ps

// Event deadline scheduler: running timestamp, per-token last sync time and
// deadline, and the earliest deadline over all tokens.
// Request channel: a transfer happens on a rising edge with start high and
// busy low; req_type, req_token and req_amount are sampled at that edge.
// Result channel: exactly one result per request, shown for one cycle with
// rsp_strobe high; the receiver cannot stall, so it must take it then.
// Work after the transfer (one shared 33-bit add/compare unit walks the
// token entries): resync and advance, one subtract or add; schedule, a
// deadline write, then a sweep for the minimum; check, a gate on the
// earliest deadline, then a sweep only when some deadline may be due;
// rebase, two subtractions per token, then one for the earliest deadline;
// unknown kind, or out-of-range token for resync or schedule: no work.
// The strobe rises the cycle after the last work cycle, and busy is low in
// that same cycle, so a new request can be taken while a result is shown.
// Synchronous reset clears the timestamp, all token entries and the earliest
// deadline to zero and leaves the block idle.

module event_deadline_scheduler_top #(
   parameter int NUM_TOKENS = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_type,
   input  logic [2:0]          req_token,
   input  logic signed [31:0]  req_amount,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_elapsed,
   output logic                rsp_negative_sync,
   output logic [7:0]          rsp_due_mask,
   output logic signed [31:0]  rsp_earliest_deadline
);

   localparam int IDX_W = (NUM_TOKENS > 1) ? $clog2(NUM_TOKENS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TOKENS - 1);
   localparam logic [eds_pkg::TOKEN_W:0] TOKEN_LIMIT =
      (eds_pkg::TOKEN_W + 1)'(NUM_TOKENS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RESYNC,
      S_SCHED_WR,
      S_SCHED_MIN,
      S_ADVANCE,
      S_CHECK_GATE,
      S_CHECK_SCAN,
      S_REBASE_SYNC,
      S_REBASE_DL,
      S_REBASE_EARLY
   } state_type;

   state_type                    state_ff, state_in;
   logic [IDX_W-1:0]             cnt_ff, cnt_in;
   logic [IDX_W-1:0]             tok_ff, tok_in;
   logic [eds_pkg::TIME_W-1:0]   amount_ff, amount_in;
   logic [eds_pkg::TIME_W-1:0]   ct_ff, ct_in;
   logic [eds_pkg::TIME_W-1:0]   earliest_ff, earliest_in;
   logic [eds_pkg::TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic                         neg_ff, neg_in;
   logic [eds_pkg::MASK_W-1:0]   mask_ff, mask_in;
   logic [eds_pkg::TIME_W-1:0]   rsp_earliest_ff, rsp_earliest_in;
   logic                         strobe_ff, done;

   logic                         tok_ok;
   logic                         last;
   logic                         le;
   eds_pkg::alu_op_type          alu_op;
   logic [eds_pkg::TIME_W-1:0]   alu_a, alu_b, alu_res;
   eds_pkg::alu_flags_type       flags;
   logic [IDX_W-1:0]             st_addr;
   eds_pkg::store_wr_type        st_wr;
   logic [eds_pkg::TIME_W-1:0]   st_wr_data;
   logic [eds_pkg::TIME_W-1:0]   sync_rd, dl_rd;

   eds_alu u_alu (
      .op    (alu_op),
      .a     (alu_a),
      .b     (alu_b),
      .res   (alu_res),
      .flags (flags)
   );

   eds_token_store #(
      .NUM_TOKENS (NUM_TOKENS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .addr    (st_addr),
      .wr      (st_wr),
      .wr_data (st_wr_data),
      .sync_rd (sync_rd),
      .dl_rd   (dl_rd)
   );

   assign tok_ok = ({1'b0, req_token} < TOKEN_LIMIT);
   assign last   = (cnt_ff == LAST_IDX);
   assign le     = flags.lt | flags.eq;

   // token-addressed steps use the request token, sweeps use the counter
   assign st_addr = (state_ff == S_RESYNC || state_ff == S_SCHED_WR) ? tok_ff : cnt_ff;

   // sequencer: operand selection and next values
   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      tok_in      = tok_ff;
      amount_in   = amount_ff;
      ct_in       = ct_ff;
      earliest_in = earliest_ff;
      elapsed_in  = elapsed_ff;
      neg_in      = neg_ff;
      mask_in     = mask_ff;
      done        = 1'b0;
      alu_op      = eds_pkg::ALU_SUB;
      alu_a       = ct_ff;
      alu_b       = amount_ff;
      st_wr       = '0;
      st_wr_data  = alu_res;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               tok_in     = req_token[IDX_W-1:0];
               amount_in  = $unsigned(req_amount);
               cnt_in     = '0;
               elapsed_in = '0;
               neg_in     = 1'b0;
               mask_in    = '0;
               unique case (req_type)
                  eds_pkg::REQ_RESYNC: begin
                     if (tok_ok) state_in = S_RESYNC;
                     else        done = 1'b1;
                  end
                  eds_pkg::REQ_SCHEDULE: begin
                     if (tok_ok) state_in = S_SCHED_WR;
                     else        done = 1'b1;
                  end
                  eds_pkg::REQ_ADVANCE: state_in = S_ADVANCE;
                  eds_pkg::REQ_CHECK:   state_in = S_CHECK_GATE;
                  eds_pkg::REQ_REBASE:  state_in = S_REBASE_SYNC;
                  default:              done = 1'b1;
               endcase
            end
         end

         // elapsed since last sync, then record the sync
         S_RESYNC: begin
            alu_b         = sync_rd;
            elapsed_in    = alu_res;
            neg_in        = alu_res[eds_pkg::TIME_W-1];
            st_wr.sync_we = 1'b1;
            st_wr_data    = ct_ff;
            state_in      = S_IDLE;
            done          = 1'b1;
         end

         S_SCHED_WR: begin
            alu_op      = eds_pkg::ALU_ADD;
            st_wr.dl_we = 1'b1;
            state_in    = S_SCHED_MIN;
         end

         // running signed minimum over all deadlines
         S_SCHED_MIN: begin
            alu_a = dl_rd;
            alu_b = earliest_ff;
            if (cnt_ff == '0 || flags.lt) begin
               earliest_in = dl_rd;
            end
            if (last) begin
               state_in = S_IDLE;
               done     = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_ADVANCE: begin
            alu_op   = eds_pkg::ALU_ADD;
            ct_in    = alu_res;
            state_in = S_IDLE;
            done     = 1'b1;
         end

         // nothing due when the earliest deadline is still ahead
         S_CHECK_GATE: begin
            alu_a = earliest_ff;
            alu_b = ct_ff;
            if (le) begin
               state_in = S_CHECK_SCAN;
            end else begin
               state_in = S_IDLE;
               done     = 1'b1;
            end
         end

         S_CHECK_SCAN: begin
            alu_a = dl_rd;
            alu_b = ct_ff;
            if (le) begin
               mask_in = mask_ff | (eds_pkg::MASK_W'(1) << cnt_ff);
            end
            if (last) begin
               state_in = S_IDLE;
               done     = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_REBASE_SYNC: begin
            alu_a         = sync_rd;
            alu_b         = ct_ff;
            st_wr.sync_we = 1'b1;
            state_in      = S_REBASE_DL;
         end

         S_REBASE_DL: begin
            alu_a       = dl_rd;
            alu_b       = ct_ff;
            st_wr.dl_we = 1'b1;
            if (last) begin
               state_in = S_REBASE_EARLY;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = S_REBASE_SYNC;
            end
         end

         S_REBASE_EARLY: begin
            alu_a       = earliest_ff;
            alu_b       = ct_ff;
            earliest_in = alu_res;
            ct_in       = '0;
            state_in    = S_IDLE;
            done        = 1'b1;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_earliest_in = done ? earliest_in : rsp_earliest_ff;

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         strobe_ff   <= 1'b0;
         ct_ff       <= '0;
         earliest_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         strobe_ff   <= done;
         ct_ff       <= ct_in;
         earliest_ff <= earliest_in;
      end
      tok_ff          <= tok_in;
      amount_ff       <= amount_in;
      elapsed_ff      <= elapsed_in;
      neg_ff          <= neg_in;
      mask_ff         <= mask_in;
      rsp_earliest_ff <= rsp_earliest_in;
   end

   assign busy                  = (state_ff != S_IDLE);
   assign rsp_strobe            = strobe_ff;
   assign rsp_elapsed           = $signed(elapsed_ff);
   assign rsp_negative_sync     = neg_ff;
   assign rsp_due_mask          = mask_ff;
   assign rsp_earliest_deadline = $signed(rsp_earliest_ff);

   // a result only follows a transfer or work in progress
   a_strobe_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start)))
      else $error("result strobe without a request");

   // an accepted request either finishes at once or keeps the block busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request lost");

   // sweep counter never leaves the token range
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST_IDX)
      else $error("sweep counter out of range");

   // no due bit for a token that does not exist
   a_mask_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_due_mask >> NUM_TOKENS) == '0))
      else $error("due bit beyond token count");

   // negative flag agrees with the sign of elapsed
   a_neg_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_negative_sync == rsp_elapsed[31]))
      else $error("negative flag mismatch");

endmodule
